FILE: design/bbr_pkg.sv
package bbr_pkg;

  // Samples per block and the widths that follow from it.
  localparam int BlockSize = 32;
  localparam int IdxW      = $clog2(BlockSize);
  localparam int NumAxes   = 3;

  localparam int SampleW = 20;
  localparam int DeltaW  = SampleW + 1;
  localparam int SumW    = SampleW + IdxW;
  localparam int CountW  = 11;
  localparam int DenW    = CountW + 1;
  // Signed numerator count*baseline + block sum, with headroom for the add.
  localparam int NumW    = CountW + SampleW + 1;
  localparam int StepW   = $clog2(NumW);

  localparam logic [CountW-1:0] LimitReset = CountW'(2000);

  // Strobes from the sequencer to every axis lane.
  typedef struct packed {
    logic accept;  // An item is taken this cycle.
    logic mul;     // Form count*baseline.
    logic load;    // Form the numerator and start the divider.
    logic step;    // One quotient bit.
    logic finish;  // Write the new baseline and clear the block sum.
  } bbr_ctl_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StLoad = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } bbr_state_e;

endpackage

FILE: design/bbr_div.sv
module bbr_div (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      step_i,
  input  logic [bbr_pkg::NumW-1:0]  num_i,
  input  logic [bbr_pkg::DenW-1:0]  den_i,
  output logic [bbr_pkg::NumW-1:0]  quo_o
);
  import bbr_pkg::*;

  // Restoring division, one quotient bit per step. The dividend shifts out of
  // the top of quo_q while quotient bits shift in at the bottom.
  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   trial;

  always_comb begin
    trial = {rem_q, quo_q[NumW-1]};
    rem_d = rem_q;
    quo_d = quo_q;
    if (load_i) begin
      rem_d = '0;
      quo_d = num_i;
    end else if (step_i) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = DenW'(trial - {1'b0, den_i});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

FILE: design/bbr_lane.sv
module bbr_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bbr_pkg::bbr_ctl_t                ctl_i,
  input  logic [bbr_pkg::CountW-1:0]       cnt_i,
  input  logic [bbr_pkg::DenW-1:0]         den_i,
  input  logic signed [bbr_pkg::SampleW-1:0] sample_i,
  output logic signed [bbr_pkg::DeltaW-1:0]  delta_o
);
  import bbr_pkg::*;

  logic signed [SampleW-1:0] base_q, base_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [NumW-1:0]    prod_q, prod_d;
  logic signed [NumW-1:0]    num;
  logic [NumW-1:0]           mag;
  logic                      neg_q;
  logic [NumW-1:0]           quo;
  logic [SampleW-1:0]        quo_lo;

  assign delta_o = DeltaW'(sample_i) - DeltaW'(base_q);

  assign prod_d = NumW'($signed({1'b0, cnt_i})) * NumW'(base_q);
  assign num    = prod_q + NumW'(sum_q);
  assign mag    = num[NumW-1] ? NumW'(-num) : NumW'(num);

  // The quotient magnitude of a weighted mean fits the sample width.
  assign quo_lo = quo[SampleW-1:0];
  assign base_d = neg_q ? $signed(SampleW'(-quo_lo)) : $signed(quo_lo);

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.finish) begin
      sum_d = '0;
    end else if (ctl_i.accept) begin
      sum_d = sum_q + SumW'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      sum_q  <= '0;
    end else begin
      sum_q <= sum_d;
      if (ctl_i.finish) begin
        base_q <= base_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctl_i.load) begin
      neg_q <= num[NumW-1];
    end
  end

  bbr_div u_div (
    .clk_i  (clk_i),
    .load_i (ctl_i.load),
    .step_i (ctl_i.step),
    .num_i  (mag),
    .den_i  (den_i),
    .quo_o  (quo)
  );

endmodule

FILE: design/block_baseline_removal_3axis_unit.sv
// A result is registered and offered in the cycle after its item is taken.
// Throughput: one item per cycle inside a block unless the output is stalled; after
// a block's last item the input stalls while each lane runs its 32-step divider.
// Reset (rst_ni low, asynchronous) clears baselines, block sums, position and
// weight count, sets the count limit to 2000 and empties the output register.
module block_baseline_removal_3axis_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bbr_pkg::CountW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [bbr_pkg::SampleW-1:0]  sample_x_i,
  input  logic signed [bbr_pkg::SampleW-1:0]  sample_y_i,
  input  logic signed [bbr_pkg::SampleW-1:0]  sample_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bbr_pkg::DeltaW-1:0]   delta_x_o,
  output logic signed [bbr_pkg::DeltaW-1:0]   delta_y_o,
  output logic signed [bbr_pkg::DeltaW-1:0]   delta_z_o,
  output logic                                block_end_o
);
  import bbr_pkg::*;

  // Sequencer state. Between blocks the sequencer walks through a multiply
  // cycle, a numerator cycle, the divider steps and a write-back cycle.
  bbr_state_e state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CountW-1:0] weight_q, weight_d;
  logic [CountW-1:0] limit_q;
  logic [DenW-1:0]   den;
  logic [DenW-1:0]   weight_next;
  logic              last;
  logic              accept;
  bbr_ctl_t          ctl;

  logic signed [SampleW-1:0] sample [NumAxes];
  logic signed [DeltaW-1:0]  delta  [NumAxes];

  logic                     out_valid_q;
  logic signed [DeltaW-1:0] delta_q [NumAxes];
  logic                     block_end_q;

  assign sample[0] = sample_x_i;
  assign sample[1] = sample_y_i;
  assign sample[2] = sample_z_i;

  // New items are taken only between block updates, and only when the output
  // register is empty or is being emptied in this same cycle.
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (idx_q == IdxW'(BlockSize - 1));

  // The divisor stays fixed for the whole division since the weight count
  // changes only in the write-back cycle.
  assign den         = DenW'(weight_q) + DenW'(BlockSize);
  assign weight_next = den;

  always_comb begin
    ctl        = '0;
    ctl.accept = accept;
    ctl.mul    = (state_q == StMul);
    ctl.load   = (state_q == StLoad);
    ctl.step   = (state_q == StDiv);
    ctl.finish = (state_q == StDone);
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    idx_d    = idx_q;
    weight_d = weight_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (last) begin
            idx_d   = '0;
            state_d = StMul;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      StMul: begin
        state_d = StLoad;
      end
      StLoad: begin
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(NumW - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // The count saturates at the limit and drops to it if the limit fell.
        if (weight_next > DenW'(limit_q)) begin
          weight_d = limit_q;
        end else begin
          weight_d = weight_next[CountW-1:0];
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      step_q   <= '0;
      idx_q    <= '0;
      weight_q <= '0;
      limit_q  <= LimitReset;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      idx_q    <= idx_d;
      weight_q <= weight_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // One lane per axis; each holds its baseline, block sum and divider.
  for (genvar g = 0; g < NumAxes; g++) begin : gen_lane
    bbr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .cnt_i    (weight_q),
      .den_i    (den),
      .sample_i (sample[g]),
      .delta_o  (delta[g])
    );
  end

  // Merge stage: the three lane differences and the block flag are captured
  // together into one output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int a = 0; a < NumAxes; a++) begin
        delta_q[a] <= delta[a];
      end
      block_end_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign delta_x_o   = delta_q[0];
  assign delta_y_o   = delta_q[1];
  assign delta_z_o   = delta_q[2];
  assign block_end_o = block_end_q;

endmodule

FILE: sim/testbench.sv
module testbench;
  import bbr_pkg::*;

  // Widths of the sample and delta ports, taken from the package.
  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [DeltaW-1:0]  delta_t;

  // One accelerometer item and one baseline-removed result.
  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } accel_t;

  typedef struct packed {
    delta_t x;
    delta_t y;
    delta_t z;
    logic   block_end;
  } delta_res_t;

  // A row of the directed table. When typed is set, the expected result is
  // written in the row; otherwise it comes from the baseline predictor.
  typedef struct {
    int x;
    int y;
    int z;
    bit typed;
    int wx;
    int wy;
    int wz;
    bit wend;
  } dir_row_t;

  localparam int SampleMax    = 524287;
  localparam int SampleMin    = -524288;
  localparam int NumDirected  = 22;
  localparam int NumPhases    = 8;
  // The block stalls after a block end while it divides, and this is enough
  // for the baseline and weight count to settle.
  localparam int SettleCycles = 50;
  localparam int DrainLimit   = 5000;
  localparam int LongHold     = 300;
  localparam int CycleLimit   = 200000;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CountW-1:0]   cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready_o;
  sample_t             sample_x    = '0;
  sample_t             sample_y    = '0;
  sample_t             sample_z    = '0;
  logic                out_valid_o;
  logic                out_ready   = 1'b0;
  delta_t              delta_x_o;
  delta_t              delta_y_o;
  delta_t              delta_z_o;
  logic                block_end_o;

  block_baseline_removal_3axis_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .sample_x_i  (sample_x),
    .sample_y_i  (sample_y),
    .sample_z_i  (sample_z),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .delta_x_o   (delta_x_o),
    .delta_y_o   (delta_y_o),
    .delta_z_o   (delta_z_o),
    .block_end_o (block_end_o)
  );

  // Clock with a period of 4 time units.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The predictor keeps its own copy of the block's state. Baselines and block
  // sums are held in 64 bits so that the weighted mean never overflows.
  longint      baseline_q  [NumAxes] = '{default: 0};
  longint      block_sum_q [NumAxes] = '{default: 0};
  int unsigned pos_in_block = 0;
  int unsigned weight_cnt   = 0;
  int unsigned count_limit  = LimitReset;

  // Results in the order the block must deliver them.
  delta_res_t pending_deltas [$];

  int mismatches   = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int burst_left   = 0;

  // Random stimulus profile, chosen afresh at the start of every block: a
  // per-axis center and a noise span around it (a negative span means any
  // 20-bit pattern at all).
  longint drift_center [NumAxes];
  int     noise_span;

  // Subtract the baseline held at the start of the block, accumulate the
  // block sum and, on the last item of a block, fold the sum into the
  // running weighted mean. Signed 64-bit division truncates toward zero,
  // which is exactly the rounding the block must use.
  function automatic delta_res_t remove_baseline(input accel_t smp);
    longint     s [NumAxes];
    longint     d [NumAxes];
    longint     cnt;
    longint     next_cnt;
    bit         last;
    delta_res_t res;
    s[0] = smp.x;
    s[1] = smp.y;
    s[2] = smp.z;
    last = (pos_in_block >= BlockSize - 1);
    for (int j = 0; j < NumAxes; j++) begin
      d[j] = s[j] - baseline_q[j];
      block_sum_q[j] += s[j];
    end
    res.x         = d[0][DeltaW-1:0];
    res.y         = d[1][DeltaW-1:0];
    res.z         = d[2][DeltaW-1:0];
    res.block_end = last;
    if (last) begin
      cnt = weight_cnt;
      for (int j = 0; j < NumAxes; j++) begin
        baseline_q[j]  = (cnt * baseline_q[j] + block_sum_q[j]) / (cnt + BlockSize);
        block_sum_q[j] = 0;
      end
      // The saturation applies even when the limit is below the block size,
      // so the count may sit at a small value or at zero.
      next_cnt = cnt + BlockSize;
      if (next_cnt > count_limit) begin
        next_cnt = count_limit;
      end
      weight_cnt   = next_cnt;
      pos_in_block = 0;
    end else begin
      pos_in_block++;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Offer one item and hold it until the block takes it. The sender works in
  // bursts: when a burst runs out, valid usually drops for a random gap.
  task automatic offer_sample(input accel_t smp, input bit typed, input delta_res_t typed_want);
    delta_res_t predicted;
    in_valid <= 1'b1;
    sample_x <= smp.x;
    sample_y <= smp.y;
    sample_z <= smp.z;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = remove_baseline(smp);
    pending_deltas.push_back(typed ? typed_want : predicted);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic sample_t draw_axis(input longint center);
    longint v;
    if (noise_span < 0) begin
      // Full range, with the rails showing up more often than chance gives.
      case ($urandom_range(0, 7))
        0:       v = SampleMax;
        1:       v = SampleMin;
        default: v = sample_t'($urandom());
      endcase
    end else begin
      v = center + longint'($urandom_range(0, 2 * noise_span)) - noise_span;
      if (v > SampleMax) v = SampleMax;
      if (v < SampleMin) v = SampleMin;
    end
    return v[SampleW-1:0];
  endfunction

  task automatic send_random(input int count);
    accel_t smp;
    for (int i = 0; i < count; i++) begin
      if (pos_in_block == 0) begin
        for (int j = 0; j < NumAxes; j++) begin
          if ($urandom_range(0, 3) == 0) begin
            drift_center[j] = $urandom_range(0, 1) ? SampleMax : SampleMin;
          end else begin
            drift_center[j] = sample_t'($urandom());
          end
        end
        case ($urandom_range(0, 4))
          0:       noise_span = 0;
          1:       noise_span = 16;
          2:       noise_span = 4096;
          default: noise_span = -1;
        endcase
      end
      smp.x = draw_axis(drift_center[0]);
      smp.y = draw_axis(drift_center[1]);
      smp.z = draw_axis(drift_center[2]);
      offer_sample(smp, 1'b0, '0);
    end
  endtask

  // Stop offering, wait for every outstanding result, then let the divider
  // finish any block end so that the block is idle for a register write.
  task automatic wait_until_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_deltas.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_deltas.size() != 0) begin
      report_mismatch($sformatf("%0d results never delivered", pending_deltas.size()));
      pending_deltas.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_limit(input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CountW-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    count_limit = value[CountW-1:0];
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: the run has hung if it gets this far.
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("FAIL block_baseline_removal_3axis_unit");
    $finish;
  end

  // Receiver. It follows a 16-bit ready pattern, rotated every cycle and
  // redrawn when pattern_age wraps, sometimes all ones so there are stretches with
  // no stalls. Once, after enough results, it holds ready low for a long
  // stretch while the sender keeps offering, so the output register fills
  // and the block has to stall its input.
  initial begin : receiver
    logic [15:0] ready_pattern;
    int          pattern_age;
    bit          long_hold_done;
    ready_pattern  = '1;
    pattern_age    = 0;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && results_seen >= 120) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        out_ready     <= ready_pattern[0];
        ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
        pattern_age++;
        if (pattern_age == 64) begin
          pattern_age   = 0;
          ready_pattern = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom());
        end
      end
    end
  end

  // Result checker: every accepted result is compared with the oldest
  // expectation. Outputs are read at the edge, before this edge's updates.
  always @(posedge clk_i) begin : check_results
    delta_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_deltas.size() == 0) begin
        report_mismatch("result delivered with no item outstanding");
      end else begin
        want = pending_deltas.pop_front();
        if (delta_x_o !== want.x) begin
          report_mismatch($sformatf("delta_x got %0d want %0d", delta_x_o, want.x));
        end
        if (delta_y_o !== want.y) begin
          report_mismatch($sformatf("delta_y got %0d want %0d", delta_y_o, want.y));
        end
        if (delta_z_o !== want.z) begin
          report_mismatch($sformatf("delta_z got %0d want %0d", delta_z_o, want.z));
        end
        if (block_end_o !== want.block_end) begin
          report_mismatch($sformatf("block_end got %b want %b", block_end_o,
                                    want.block_end));
        end
      end
    end
  end

  // Main sequence. Phase one runs with the reset limit of 2000; each later
  // phase writes a new limit once the block is idle. The plan walks the
  // extremes (0, the low and high ends of the range, all ones), limits below
  // the block size, and limits that drop below the weight count already
  // reached so that the count has to fall at the next block end.
  initial begin : stimulus
    dir_row_t    directed_rows [NumDirected];
    int unsigned limit_plan [NumPhases];
    accel_t      smp;
    delta_res_t  want;

    // Right after reset every baseline is zero, so each delta is just the
    // sample itself and no block has ended yet.
    directed_rows = '{
      '{SampleMax, SampleMax, SampleMax, 1'b1, SampleMax, SampleMax, SampleMax, 1'b0},
      '{SampleMin, SampleMin, SampleMin, 1'b1, SampleMin, SampleMin, SampleMin, 1'b0},
      '{0,         0,         0,         1'b1, 0,         0,         0,         1'b0},
      '{-1,        -1,        -1,        1'b1, -1,        -1,        -1,        1'b0},
      '{SampleMax, SampleMin, 0,         1'b1, SampleMax, SampleMin, 0,         1'b0},
      '{SampleMin, 0,         SampleMax, 1'b1, SampleMin, 0,         SampleMax, 1'b0},
      '{0,         SampleMax, SampleMin, 1'b1, 0,         SampleMax, SampleMin, 1'b0},
      '{1,         -1,        2,         1'b1, 1,         -1,        2,         1'b0},
      '{-2,        3,         -4,        1'b1, -2,        3,         -4,        1'b0},
      '{349525,    -349526,   349525,    1'b1, 349525,    -349526,   349525,    1'b0},
      '{-349526,   349525,    -349526,   1'b1, -349526,   349525,    -349526,   1'b0},
      '{262144,    -262144,   131072,    1'b1, 262144,    -262144,   131072,    1'b0},
      '{-262145,   262143,    -131073,   1'b1, -262145,   262143,    -131073,   1'b0},
      '{4096,      -4096,     1000,      1'b1, 4096,      -4096,     1000,      1'b0},
      '{SampleMax, SampleMax, SampleMin, 1'b1, SampleMax, SampleMax, SampleMin, 1'b0},
      '{SampleMin, SampleMin, SampleMax, 1'b1, SampleMin, SampleMin, SampleMax, 1'b0},
      '{65535,     -65536,    32767,     1'b1, 65535,     -65536,    32767,     1'b0},
      '{-100,      200,       -300,      1'b1, -100,      200,       -300,      1'b0},
      '{SampleMax, 0,         -1,        1'b1, SampleMax, 0,         -1,        1'b0},
      '{SampleMin, -1,        1,         1'b1, SampleMin, -1,        1,         1'b0},
      '{12345,     -54321,    500000,    1'b1, 12345,     -54321,    500000,    1'b0},
      '{-500000,   499999,    -7,        1'b1, -500000,   499999,    -7,        1'b0}
    };
    limit_plan = '{2016, 0, 5, 2047, 32, 160, 40, 1024};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      smp.x          = directed_rows[i].x;
      smp.y          = directed_rows[i].y;
      smp.z          = directed_rows[i].z;
      want.x         = directed_rows[i].wx;
      want.y         = directed_rows[i].wy;
      want.z         = directed_rows[i].wz;
      want.block_end = directed_rows[i].wend;
      offer_sample(smp, directed_rows[i].typed, want);
    end
    send_random(42);

    for (int p = 0; p < NumPhases; p++) begin
      wait_until_drained();
      program_limit(limit_plan[p]);
      send_random($urandom_range(40, 56));
    end
    wait_until_drained();

    if (mismatches == 0) begin
      $display("PASS block_baseline_removal_3axis_unit");
    end else begin
      $display("FAIL block_baseline_removal_3axis_unit");
    end
    $finish;
  end

endmodule
